/* rtl/core/tbu_pkg.sv */
// Timer bank package: sizes, command codes, channel words and the timer entry.
// Used by every file of the timer bank; depends on nothing.
package tbu_pkg;

    localparam int NUM_TIMERS  = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int PTR_W       = $clog2(NUM_TIMERS + 1);
    localparam int MAX_EVENTS  = 16;
    localparam int EVT_CNT_W   = $clog2(MAX_EVENTS + 1);

    typedef enum logic [2:0] {
        CMD_TICK      = 3'd0,
        CMD_SETUP     = 3'd1,
        CMD_START     = 3'd2,
        CMD_START_NOW = 3'd3,
        CMD_STOP      = 3'd4
    } tbu_cmd_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [3:0]  timer_index;
        logic [31:0] reload_value;
        logic        periodic;
        logic        notify_enable;
    } cmd_word_t;

    typedef struct packed {
        logic [3:0] expired_index;
        logic       last;
    } evt_word_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] reload;
        logic [COUNT_WIDTH-1:0] count;
        logic                   running;
        logic                   periodic;
        logic                   notify;
    } entry_t;

    typedef struct packed {
        tbu_cmd_t               cmd;
        logic [COUNT_WIDTH-1:0] value;
        logic                   periodic;
        logic                   notify;
    } upd_req_t;

    typedef struct packed {
        entry_t entry;
        logic   expired;
    } upd_res_t;

endpackage

/* rtl/core/multi_channel_timer_bank_unit.sv */
// Timer bank top level: command channel, event channel, scan sequencer.
// Depends on tbu_pkg, tbu_mem and tbu_update.
//
// Usage:
//   The command channel (cmd_valid / cmd_stall / cmd_word) takes one word per
//   command. Set up, start, start now and stop read the addressed entry and
//   write it back, with cmd_stall high during the write-back. Commands to an
//   index beyond the bank and unknown codes are dropped without leaving idle.
//   A tick sweeps every entry through the memory's one read port, one entry per
//   cycle unless the sweep halts for the event channel, with cmd_stall high
//   until the sweep ends and any held word has gone into the output register.
//   Each reported expiry leaves on the event channel (evt_valid / evt_stall /
//   evt_word) in ascending index order. The latest found expiry is held back
//   until the next one turns up or the sweep ends, so the final word of a
//   tick carries last = 1. At most MAX_EVENTS words leave per tick.
//   An output register parts the channels: a stalled event word holds, and
//   the sweep halts only when it must push a word while the register's word is stalled.
//   Reset clears the control state and the per-entry valid bits, so every
//   timer reads as all zero until first written. No clearing pass is needed.
module multi_channel_timer_bank_unit
    import tbu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_stall,
    input  cmd_word_t cmd_word,
    output logic      evt_valid,
    input  logic      evt_stall,
    output evt_word_t evt_word
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_CMD   = 4'b0010,
        ST_SCAN  = 4'b0100,
        ST_FLUSH = 4'b1000
    } tbu_state_t;

    tbu_state_t           state_reg, state_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic                 p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]     p_idx_reg, p_idx_next;
    logic                 hold_vld_reg, hold_vld_next;
    logic [IDX_W-1:0]     hold_idx_reg, hold_idx_next;
    logic [EVT_CNT_W-1:0] ev_cnt_reg, ev_cnt_next;
    logic                 out_vld_reg, out_vld_next;
    evt_word_t            out_word_reg, out_word_next;
    upd_req_t             cmd_req_reg, cmd_req_next;
    logic [IDX_W-1:0]     cmd_addr_reg, cmd_addr_next;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    entry_t               rd_data;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    upd_req_t             upd_req;
    upd_res_t             upd_res;

    logic                 accept;
    logic                 out_free;
    logic                 idx_ok;
    logic                 cmd_known;
    logic                 report;
    logic                 blocked;

    tbu_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (upd_res.entry)
    );

    tbu_update u_update (
        .req (upd_req),
        .cur (rd_data),
        .res (upd_res)
    );

    assign cmd_stall = (state_reg != ST_IDLE);
    assign accept    = cmd_valid && !cmd_stall;
    assign evt_valid = out_vld_reg;
    assign evt_word  = out_word_reg;
    assign out_free  = !out_vld_reg || !evt_stall;

    assign idx_ok    = int'(cmd_word.timer_index) < NUM_TIMERS;
    assign cmd_known = (cmd_word.command == CMD_SETUP) || (cmd_word.command == CMD_START)
                    || (cmd_word.command == CMD_START_NOW)
                    || (cmd_word.command == CMD_STOP);

    // during a sweep the update unit runs the tick step
    always_comb
    begin
        upd_req = cmd_req_reg;
        if (state_reg == ST_SCAN)
        begin
            upd_req.cmd = CMD_TICK;
        end
    end

    // an expiry worth a word; it stalls the sweep only if a held word must
    // move out while the output register is occupied and stalled
    assign report  = p_vld_reg && upd_res.expired && rd_data.notify
                  && (int'(ev_cnt_reg) < MAX_EVENTS);
    assign blocked = report && hold_vld_reg && !out_free;

    always_comb
    begin
        state_next    = state_reg;
        rd_ptr_next   = rd_ptr_reg;
        p_vld_next    = p_vld_reg;
        p_idx_next    = p_idx_reg;
        hold_vld_next = hold_vld_reg;
        hold_idx_next = hold_idx_reg;
        ev_cnt_next   = ev_cnt_reg;
        out_vld_next  = out_vld_reg;
        out_word_next = out_word_reg;
        cmd_req_next  = cmd_req_reg;
        cmd_addr_next = cmd_addr_reg;
        rd_en         = 1'b0;
        rd_addr       = p_idx_reg;
        wr_en         = 1'b0;
        wr_addr       = p_idx_reg;

        // drain the output register
        if (out_vld_reg && !evt_stall)
        begin
            out_vld_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd_word.command == CMD_TICK)
                    begin
                        rd_ptr_next = '0;
                        p_vld_next  = 1'b0;
                        ev_cnt_next = '0;
                        state_next  = ST_SCAN;
                    end
                    else if (cmd_known && idx_ok)
                    begin
                        rd_en                 = 1'b1;
                        rd_addr               = IDX_W'(cmd_word.timer_index);
                        cmd_addr_next         = IDX_W'(cmd_word.timer_index);
                        cmd_req_next.cmd      = tbu_cmd_t'(cmd_word.command);
                        cmd_req_next.value    = COUNT_WIDTH'(cmd_word.reload_value);
                        cmd_req_next.periodic = cmd_word.periodic;
                        cmd_req_next.notify   = cmd_word.notify_enable;
                        state_next            = ST_CMD;
                    end
                end
            end
            ST_CMD:
            begin
                wr_en      = 1'b1;
                wr_addr    = cmd_addr_reg;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                if (!blocked)
                begin
                    wr_en = p_vld_reg;
                    if (report)
                    begin
                        if (hold_vld_reg)
                        begin
                            out_vld_next               = 1'b1;
                            out_word_next.expired_index = 4'(hold_idx_reg);
                            out_word_next.last         = 1'b0;
                        end
                        hold_vld_next = 1'b1;
                        hold_idx_next = p_idx_reg;
                        ev_cnt_next   = ev_cnt_reg + EVT_CNT_W'(1);
                    end
                    if (int'(rd_ptr_reg) < NUM_TIMERS)
                    begin
                        rd_en       = 1'b1;
                        rd_addr     = rd_ptr_reg[IDX_W-1:0];
                        p_idx_next  = rd_ptr_reg[IDX_W-1:0];
                        p_vld_next  = 1'b1;
                        rd_ptr_next = rd_ptr_reg + PTR_W'(1);
                    end
                    else
                    begin
                        p_vld_next = 1'b0;
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH:
            begin
                // release the held word as the final one of this tick
                if (!hold_vld_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_vld_next               = 1'b1;
                    out_word_next.expired_index = 4'(hold_idx_reg);
                    out_word_next.last         = 1'b1;
                    hold_vld_next              = 1'b0;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rd_ptr_reg   <= '0;
            p_vld_reg    <= 1'b0;
            hold_vld_reg <= 1'b0;
            ev_cnt_reg   <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_ptr_reg   <= rd_ptr_next;
            p_vld_reg    <= p_vld_next;
            hold_vld_reg <= hold_vld_next;
            ev_cnt_reg   <= ev_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_idx_reg    <= p_idx_next;
        hold_idx_reg <= hold_idx_next;
        out_word_reg <= out_word_next;
        cmd_req_reg  <= cmd_req_next;
        cmd_addr_reg <= cmd_addr_next;
    end

    // a command write-back always returns to idle
    a_cmd_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CMD |=> state_reg == ST_IDLE)
        else $error("command write-back did not return to idle");

    // never more words per tick than the event limit
    a_event_limit: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ev_cnt_reg) <= MAX_EVENTS)
        else $error("event count beyond limit");

    // a held word exists only while a tick is in progress
    a_hold_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        hold_vld_reg |-> (state_reg == ST_SCAN || state_reg == ST_FLUSH))
        else $error("held event word outside a tick");

    // the sweep never reads the entry it is writing back
    a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write to the same entry in one cycle");

endmodule

/* rtl/core/tbu_mem.sv */
// Timer entry store: one synchronous read port with registered read data, one write port.
// Depends on tbu_pkg; per-entry valid bits make unwritten entries read as zero.
module tbu_mem
    import tbu_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data
);

    entry_t                  mem_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]   valid_reg;
    entry_t                  rd_data_reg;
    logic                    rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_vld_reg <= valid_reg[rd_addr];
            end
        end
    end

    // never-written entries read as the reset value
    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* rtl/core/tbu_update.sv */
// Entry update logic: new timer entry for one command or one tick step.
// Depends on tbu_pkg.
module tbu_update
    import tbu_pkg::*;
(
    input  upd_req_t req,
    input  entry_t   cur,
    output upd_res_t res
);

    logic [COUNT_WIDTH-1:0] dec;
    logic                   hit;

    assign dec = cur.count - COUNT_WIDTH'(1);
    assign hit = (dec == '0) && cur.running;

    always_comb
    begin
        res.entry   = cur;
        res.expired = 1'b0;
        unique case (req.cmd)
            CMD_TICK:
            begin
                res.expired = hit;
                // reload on periodic expiry, otherwise keep the decremented count
                res.entry.count   = (hit && cur.periodic) ? cur.reload : dec;
                res.entry.running = cur.running && !(hit && !cur.periodic);
            end
            CMD_SETUP:
            begin
                res.entry.reload   = req.value;
                res.entry.count    = req.value;
                res.entry.periodic = req.periodic;
                res.entry.notify   = req.notify;
                res.entry.running  = 1'b0;
            end
            CMD_START:
            begin
                res.entry.count   = cur.reload;
                res.entry.running = 1'b1;
            end
            CMD_START_NOW:
            begin
                res.entry.count   = COUNT_WIDTH'(1);
                res.entry.running = 1'b1;
            end
            CMD_STOP:
            begin
                res.entry.running = 1'b0;
            end
            default:
            begin
                res.entry = cur;
            end
        endcase
    end

endmodule
